@@ src/cds_pkg.sv @@
// ----------------------------------------------------------------------------
// cds_pkg: calendar date stepper shared definitions
// Command codes, controller/datapath bundles and calendar lookup functions.
// ----------------------------------------------------------------------------
package cds_pkg;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_FWD  = 2'd1;
   localparam logic [1:0] CMD_BACK = 2'd2;
   localparam logic [1:0] CMD_READ = 2'd3;

   localparam logic signed [15:0] YEAR_LO = 16'sd1700;
   localparam logic signed [15:0] YEAR_HI = 16'sd2500;

   // multiplicative inverse of 25 modulo 2^16 and divisibility bounds
   localparam logic [15:0] INV25     = 16'd23593;
   localparam logic [15:0] DIV25_LIM = 16'd1310;
   localparam logic [15:0] DIV25_NEG = 16'd64226;

   typedef struct packed {
      logic capture;
      logic prep;
      logic step;
      logic wd1;
      logic wd2;
      logic finish;
   } cds_ctl_type;

   typedef struct packed {
      logic cnt_zero;
   } cds_sts_type;

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] d;
      begin
         case (month)
            4'd2:                     d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
            default:                  d = 5'd31;
         endcase
         return d;
      end
   endfunction

   function automatic logic [2:0] month_code(input logic [3:0] month, input logic leap);
      logic [2:0] c;
      begin
         case (month)
            4'd1:    c = leap ? 3'd6 : 3'd0;
            4'd2:    c = leap ? 3'd2 : 3'd3;
            4'd3:    c = 3'd3;
            4'd4:    c = 3'd6;
            4'd5:    c = 3'd1;
            4'd6:    c = 3'd4;
            4'd7:    c = 3'd6;
            4'd8:    c = 3'd2;
            4'd9:    c = 3'd5;
            4'd10:   c = 3'd0;
            4'd11:   c = 3'd3;
            4'd12:   c = 3'd5;
            default: c = 3'd0;
         endcase
         return c;
      end
   endfunction

   // century index counted from the 1700s
   function automatic logic [2:0] century_code(input logic [2:0] cidx);
      logic [2:0] c;
      begin
         case (cidx[1:0])
            2'd0:    c = 3'd4;
            2'd1:    c = 3'd2;
            2'd2:    c = 3'd0;
            default: c = 3'd6;
         endcase
         return c;
      end
   endfunction

   // 8 = 1 mod 7, so fold octal digits twice then correct once
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [5:0] a;
      logic [3:0] b;
      begin
         a = 6'(x[7:3]) + 6'(x[2:0]);
         b = 4'(a[5:3]) + 4'(a[2:0]);
         if (b >= 4'd7) begin
            b = b - 4'd7;
         end
         return b[2:0];
      end
   endfunction

endpackage

@@ src/cds_if.sv @@
// ----------------------------------------------------------------------------
// cds_if: calendar date stepper channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface cds_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [15:0] load_year;
   logic [3:0]         load_month;
   logic [4:0]         load_day;
   logic [2:0]         load_known;
   logic [15:0]        day_count;

   modport source (
      output valid, cmd, load_year, load_month, load_day, load_known, day_count,
      input  ready
   );
   modport sink (
      input  valid, cmd, load_year, load_month, load_day, load_known, day_count,
      output ready
   );
endinterface

interface cds_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] cur_year;
   logic [3:0]         cur_month;
   logic [4:0]         cur_day;
   logic [2:0]         cur_known;
   logic [2:0]         weekday;
   logic               weekday_valid;

   modport source (
      output valid, cur_year, cur_month, cur_day, cur_known, weekday, weekday_valid,
      input  ready
   );
   modport sink (
      input  valid, cur_year, cur_month, cur_day, cur_known, weekday, weekday_valid,
      output ready
   );
endinterface

@@ src/cds_ctrl.sv @@
// ----------------------------------------------------------------------------
// cds_ctrl: calendar date stepper controller
// Sequences capture, date update, day stepping, weekday and response.
// ----------------------------------------------------------------------------
module cds_ctrl import cds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  cds_sts_type sts,
   output cds_ctl_type ctl
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_LEAP = 3'd2;
   localparam logic [2:0] ST_STEP = 3'd3;
   localparam logic [2:0] ST_WD1  = 3'd4;
   localparam logic [2:0] ST_WD2  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            ctl.prep = 1'b1;
            state_in = ST_LEAP;
         end
         ST_LEAP: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (sts.cnt_zero) begin
               state_in = ST_WD1;
            end else begin
               ctl.step = 1'b1;
            end
         end
         ST_WD1: begin
            ctl.wd1  = 1'b1;
            state_in = ST_WD2;
         end
         ST_WD2: begin
            ctl.wd2  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/cds_dp.sv @@
// ----------------------------------------------------------------------------
// cds_dp: calendar date stepper datapath
// Date registers, day counter, leap flag, weekday pipeline, output register.
// ----------------------------------------------------------------------------
module cds_dp import cds_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cds_ctl_type        ctl,
   output cds_sts_type        sts,
   input  logic [1:0]         cmd,
   input  logic signed [15:0] load_year,
   input  logic [3:0]         load_month,
   input  logic [4:0]         load_day,
   input  logic [2:0]         load_known,
   input  logic [15:0]        day_count,
   output logic signed [15:0] cur_year,
   output logic [3:0]         cur_month,
   output logic [4:0]         cur_day,
   output logic [2:0]         cur_known,
   output logic [2:0]         weekday,
   output logic               weekday_valid
);

   logic [1:0]             cmd_ff;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic signed [15:0]     ld_year_ff;
   logic [3:0]             ld_month_ff;
   logic [4:0]             ld_day_ff;
   logic [2:0]             ld_known_ff;

   logic signed [15:0]     year_ff;
   logic [3:0]             month_ff;
   logic [4:0]             day_ff;
   logic [2:0]             known_ff;
   logic                   leap_ff;

   logic                   wvalid_ff;
   logic [9:0]             off_ff;
   logic [2:0]             cidx_ff;
   logic [7:0]             sum_ff;

   logic signed [15:0]     out_year_ff;
   logic [3:0]             out_month_ff;
   logic [4:0]             out_day_ff;
   logic [2:0]             out_known_ff;
   logic [2:0]             out_wd_ff;
   logic                   out_wvalid_ff;

   // leap test
   logic [15:0] inv_prod;
   logic        div25;
   logic        leap_in;

   assign inv_prod = 16'(year_ff * INV25);
   assign div25    = (inv_prod <= DIV25_LIM) || (inv_prod >= DIV25_NEG);
   assign leap_in  = (year_ff[1:0] == 2'd0) && (!div25 || (year_ff[3:0] == 4'd0));

   // load clamping
   logic [3:0] lm_clamp;
   logic [4:0] ld_clamp;

   always_comb begin
      lm_clamp = ld_month_ff;
      if (ld_month_ff == 4'd0) begin
         lm_clamp = 4'd1;
      end else if (ld_month_ff > 4'd12) begin
         lm_clamp = 4'd12;
      end
      ld_clamp = (ld_day_ff == 5'd0) ? 5'd1 : ld_day_ff;
   end

   // one day step
   logic [5:0]         day_p1;
   logic [4:0]         lim;
   logic [3:0]         month_m1;
   logic signed [15:0] year_st;
   logic [3:0]         month_st;
   logic [4:0]         day_st;

   always_comb begin
      lim      = days_in(month_ff, leap_ff);
      day_p1   = 6'(day_ff) + 6'd1;
      month_m1 = month_ff - 4'd1;
      year_st  = year_ff;
      month_st = month_ff;
      day_st   = day_ff;
      if (cmd_ff == CMD_FWD) begin
         if (day_p1 > 6'(lim)) begin
            day_st = 5'd1;
            if (month_ff >= 4'd12) begin
               month_st = 4'd1;
               year_st  = year_ff + 16'sd1;
            end else begin
               month_st = month_ff + 4'd1;
            end
         end else begin
            day_st = day_p1[4:0];
         end
      end else begin
         if (day_ff > 5'd1) begin
            day_st = day_ff - 5'd1;
         end else if (month_ff > 4'd1) begin
            month_st = month_m1;
            day_st   = days_in(month_m1, leap_ff);
         end else begin
            month_st = 4'd12;
            year_st  = year_ff - 16'sd1;
            day_st   = days_in(4'd12, leap_ff);
         end
      end
   end

   // weekday stage 1
   logic       in_rng;
   logic [9:0] off_in;
   logic [2:0] cidx_in;

   always_comb begin
      in_rng  = (year_ff >= YEAR_LO) && (year_ff < YEAR_HI);
      off_in  = 10'(year_ff - YEAR_LO);
      cidx_in = 3'd0;
      for (int k = 1; k < 8; k++) begin
         if (off_in >= 10'(k * 100)) begin
            cidx_in = cidx_in + 3'd1;
         end
      end
   end

   // weekday stage 2
   logic [6:0] yy;
   logic [7:0] sum_in;

   always_comb begin
      yy     = 7'(off_ff - 10'(cidx_ff) * 10'd100);
      sum_in = 8'(day_ff) + 8'(month_code(month_ff, leap_ff)) + 8'(yy)
             + 8'(yy[6:2]) + 8'(century_code(cidx_ff));
   end

   assign sts.cnt_zero = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= '0;
         month_ff <= 4'd1;
         day_ff   <= 5'd1;
         known_ff <= '0;
      end else if (ctl.prep) begin
         if (cmd_ff == CMD_LOAD) begin
            day_ff   <= ld_known_ff[0] ? ld_clamp : 5'd1;
            month_ff <= ld_known_ff[1] ? lm_clamp : 4'd1;
            year_ff  <= ld_known_ff[2] ? ld_year_ff : 16'sd0;
            known_ff <= ld_known_ff;
         end else if (cmd_ff == CMD_FWD || cmd_ff == CMD_BACK) begin
            if (!known_ff[0]) begin
               day_ff <= 5'd1;
            end
            if (!known_ff[1]) begin
               month_ff <= 4'd1;
            end
            if (!known_ff[2]) begin
               year_ff <= 16'sd0;
            end
            known_ff <= 3'b111;
         end
      end else if (ctl.step) begin
         year_ff  <= year_st;
         month_ff <= month_st;
         day_ff   <= day_st;
      end
   end

   always_ff @(posedge clock) begin
      leap_ff <= leap_in;
      if (ctl.capture) begin
         cmd_ff      <= cmd;
         cnt_ff      <= (cmd == CMD_FWD || cmd == CMD_BACK) ? COUNT_WIDTH'(day_count) : '0;
         ld_year_ff  <= load_year;
         ld_month_ff <= load_month;
         ld_day_ff   <= load_day;
         ld_known_ff <= load_known;
      end else if (ctl.step) begin
         cnt_ff <= cnt_ff - COUNT_WIDTH'(1);
      end
      if (ctl.wd1) begin
         wvalid_ff <= (known_ff == 3'b111) && in_rng;
         off_ff    <= off_in;
         cidx_ff   <= cidx_in;
      end
      if (ctl.wd2) begin
         sum_ff <= sum_in;
      end
      if (ctl.finish) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= month_ff;
         out_day_ff    <= day_ff;
         out_known_ff  <= known_ff;
         out_wd_ff     <= wvalid_ff ? mod7(sum_ff) : 3'd0;
         out_wvalid_ff <= wvalid_ff;
      end
   end

   assign cur_year      = out_year_ff;
   assign cur_month     = out_month_ff;
   assign cur_day       = out_day_ff;
   assign cur_known     = out_known_ff;
   assign weekday       = out_wd_ff;
   assign weekday_valid = out_wvalid_ff;

endmodule

@@ src/calendar_date_stepper_top.sv @@
// ----------------------------------------------------------------------------
// calendar_date_stepper_top: Gregorian date register with day stepping
// Holds one date with per-field known bits; load, move forward/back, read.
// Usage:
//   req_chan carries one command per transaction (load, forward, back, read);
//   rsp_chan returns one transaction per command with the stored date,
//   known bits and weekday (0 Sunday .. 6 Saturday) plus its valid flag.
//   Moves advance one day per cycle through a single stepping unit; a move
//   of n days (n = low COUNT_WIDTH bits of day_count, 0 for load and read)
//   takes n steps before the weekday calculation starts.
//   Besides the steps, each command passes through date update, leap-flag
//   refresh, the end-of-count check, a two-stage weekday calculation and
//   the output register load.
//   Only one command is processed at a time; req_chan.ready is high while
//   the block is idle, including while a finished response waits.
//   If rsp_chan stalls, the block holds its next result until the output
//   register frees, and then accepts no new request until then.
//   Reset (synchronous) gives year 0, month 1, day 1, nothing known, and
//   drops any pending response.
// ----------------------------------------------------------------------------
module calendar_date_stepper_top import cds_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input logic     clock,
   input logic     reset,
   cds_req_if.sink   req_chan,
   cds_rsp_if.source rsp_chan
);

   cds_ctl_type ctl;
   cds_sts_type sts;

   cds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   cds_dp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .cmd           (req_chan.cmd),
      .load_year     (req_chan.load_year),
      .load_month    (req_chan.load_month),
      .load_day      (req_chan.load_day),
      .load_known    (req_chan.load_known),
      .day_count     (req_chan.day_count),
      .cur_year      (rsp_chan.cur_year),
      .cur_month     (rsp_chan.cur_month),
      .cur_day       (rsp_chan.cur_day),
      .cur_known     (rsp_chan.cur_known),
      .weekday       (rsp_chan.weekday),
      .weekday_valid (rsp_chan.weekday_valid)
   );

endmodule

@@ tb/sv/calendar_date_stepper_top_tb.sv @@
// ----------------------------------------------------------------------------
// calendar_date_stepper_top_tb: self-checking bench for the date stepper
// Drives load, forward, back and read commands through the request channel
// with random gaps, stalls the response channel at random, and compares
// every response field against a cycle-free calendar predictor in a small
// scoreboard class.
// ----------------------------------------------------------------------------
module calendar_date_stepper_top_tb;
   import cds_pkg::*;

   localparam int COUNT_WIDTH = 16;
   localparam int N_RANDOM    = 550;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] load_year;
      logic [3:0]         load_month;
      logic [4:0]         load_day;
      logic [2:0]         load_known;
      logic [15:0]        day_count;
   } date_cmd_t;

   typedef struct packed {
      logic signed [15:0] cur_year;
      logic [3:0]         cur_month;
      logic [4:0]         cur_day;
      logic [2:0]         cur_known;
      logic [2:0]         weekday;
      logic               weekday_valid;
   } date_result_t;

   class date_scoreboard;
      logic [15:0]  year;
      logic [3:0]   month;
      logic [4:0]   day;
      logic [2:0]   known;
      date_result_t due[$];
      int           errors;

      function new();
         year   = 16'd0;
         month  = 4'd1;
         day    = 5'd1;
         known  = 3'd0;
         errors = 0;
      endfunction

      function bit leap_of(logic [15:0] y);
         int v;
         begin
            v = int'($signed(y));
            if (v < 0) v = -v;
            if (v % 4 != 0) return 1'b0;
            if (v % 100 != 0) return 1'b1;
            return (v % 400) == 0;
         end
      endfunction

      function int month_length(logic [3:0] m, logic [15:0] y);
         case (m)
            4'd2:                    return leap_of(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
         endcase
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void note_request(date_cmd_t t);
         date_result_t r;
         logic [3:0]   m;
         logic [4:0]   d;
         longint       n;
         int           yv, yy, mc, cc;
         begin
            case (t.cmd)
               CMD_LOAD: begin
                  m = t.load_month;
                  d = t.load_day;
                  if (m < 4'd1) m = 4'd1;
                  if (m > 4'd12) m = 4'd12;
                  if (d < 5'd1) d = 5'd1;
                  day   = t.load_known[0] ? d : 5'd1;
                  month = t.load_known[1] ? m : 4'd1;
                  year  = t.load_known[2] ? t.load_year : 16'd0;
                  known = t.load_known;
               end
               CMD_FWD, CMD_BACK: begin
                  if (!known[0]) day = 5'd1;
                  if (!known[1]) month = 4'd1;
                  if (!known[2]) year = 16'd0;
                  known = 3'd7;
                  n = longint'(t.day_count) & ((longint'(1) << COUNT_WIDTH) - 1);
                  for (longint i = 0; i < n; i++) begin
                     if (t.cmd == CMD_FWD) begin
                        if (int'(day) >= month_length(month, year)) begin
                           day   = 5'd1;
                           month = month + 4'd1;
                        end else begin
                           day = day + 5'd1;
                        end
                        if (month > 4'd12) begin
                           month = 4'd1;
                           year  = year + 16'd1;
                        end
                     end else if (day > 5'd1) begin
                        day = day - 5'd1;
                     end else begin
                        if (month > 4'd1) begin
                           month = month - 4'd1;
                        end else begin
                           month = 4'd12;
                           year  = year - 16'd1;
                        end
                        day = 5'(month_length(month, year));
                     end
                  end
               end
               default: ;
            endcase

            r.cur_year      = year;
            r.cur_month     = month;
            r.cur_day       = day;
            r.cur_known     = known;
            r.weekday       = 3'd0;
            r.weekday_valid = 1'b0;
            yv = int'($signed(year));
            if (known == 3'd7 && yv >= 1700 && yv < 2500) begin
               yy = yv % 100;
               case (yv / 100)
                  17, 21:  cc = 4;
                  18, 22:  cc = 2;
                  19, 23:  cc = 0;
                  default: cc = 6;
               endcase
               case (month)
                  4'd1:  mc = leap_of(year) ? 6 : 0;
                  4'd2:  mc = leap_of(year) ? 2 : 3;
                  4'd3:  mc = 3;
                  4'd4:  mc = 6;
                  4'd5:  mc = 1;
                  4'd6:  mc = 4;
                  4'd7:  mc = 6;
                  4'd8:  mc = 2;
                  4'd9:  mc = 5;
                  4'd10: mc = 0;
                  4'd11: mc = 3;
                  default: mc = 5;
               endcase
               r.weekday       = 3'((int'(day) + mc + yy + yy / 4 + cc) % 7);
               r.weekday_valid = 1'b1;
            end
            due.push_back(r);
         end
      endfunction

      function void field_cmp(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(date_result_t got);
         date_result_t e;
         begin
            if (due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual year %0d", $time,
                        got.cur_year);
               errors++;
            end else begin
               e = due.pop_front();
               field_cmp("cur_year", int'(e.cur_year), int'(got.cur_year));
               field_cmp("cur_month", e.cur_month, got.cur_month);
               field_cmp("cur_day", e.cur_day, got.cur_day);
               field_cmp("cur_known", e.cur_known, got.cur_known);
               field_cmp("weekday", e.weekday, got.weekday);
               field_cmp("weekday_valid", e.weekday_valid, got.weekday_valid);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   no_idle;
   int   rsp_hold;

   date_scoreboard sb;

   cds_req_if req_chan();
   cds_rsp_if rsp_chan();

   calendar_date_stepper_top #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #100_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // response side: random stall after each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         sb.check_result('{rsp_chan.cur_year, rsp_chan.cur_month, rsp_chan.cur_day,
                           rsp_chan.cur_known, rsp_chan.weekday, rsp_chan.weekday_valid});
         rsp_hold = no_idle ? 0 : $urandom_range(0, 3);
         rsp_chan.ready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_chan.ready <= (rsp_hold == 0);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic date_cmd_t mk(logic [1:0] c, int y, int m, int d, int k, int n);
      date_cmd_t t;
      t.cmd        = c;
      t.load_year  = 16'(y);
      t.load_month = 4'(m);
      t.load_day   = 5'(d);
      t.load_known = 3'(k);
      t.day_count  = 16'(n);
      return t;
   endfunction

   task automatic send_cmd(date_cmd_t t);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= t.cmd;
      req_chan.load_year  <= t.load_year;
      req_chan.load_month <= t.load_month;
      req_chan.load_day   <= t.load_day;
      req_chan.load_known <= t.load_known;
      req_chan.day_count  <= t.day_count;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(t);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      send_cmd(mk(CMD_READ, 0, 0, 0, 0, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 0));
      send_cmd(mk(CMD_LOAD, 32767, 12, 31, 7, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_BACK, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, -4, 2, 28, 7, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, 1900, 2, 28, 7, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, 2000, 3, 1, 7, 0));
      send_cmd(mk(CMD_BACK, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, 1700, 0, 0, 7, 0));
      send_cmd(mk(CMD_LOAD, 2499, 15, 31, 3, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, 2023, 2, 31, 7, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, 2023, 2, 31, 7, 0));
      send_cmd(mk(CMD_BACK, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, 1699, 12, 31, 7, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, 2499, 12, 31, 7, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 1));
      send_cmd(mk(CMD_LOAD, -32768, 7, 13, 5, 0));
      send_cmd(mk(CMD_BACK, 0, 0, 0, 0, 0));
      send_cmd(mk(CMD_LOAD, 2024, 1, 1, 7, 0));
      send_cmd(mk(CMD_FWD, 0, 0, 0, 0, 65535));
      send_cmd(mk(CMD_BACK, 0, 0, 0, 0, 32768));
      send_cmd(mk(CMD_READ, -1, 15, 31, 7, 65535));
   endtask

   function automatic int pick_count();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return $urandom_range(0, 10);
      if (p < 90) return $urandom_range(0, 100);
      if (p < 98) return $urandom_range(0, 1000);
      return $urandom_range(0, 4095);
   endfunction

   task automatic run_random();
      date_cmd_t t;
      int        p;
      for (int i = 0; i < N_RANDOM; i++) begin
         no_idle = (i >= 200 && i < 260);
         if (i % 100 == 50) wait_drained();
         p = $urandom_range(0, 99);
         t = date_cmd_t'({$urandom, $urandom});
         if (p < 25) begin
            t.cmd = CMD_LOAD;
            if ($urandom_range(0, 3) != 0) begin
               t.load_year  = 16'($urandom_range(1600, 2600));
               t.load_month = 4'($urandom_range(1, 12));
               t.load_day   = 5'($urandom_range(1, 28));
               t.load_known = 3'd7;
            end
         end else if (p < 55) begin
            t.cmd       = CMD_FWD;
            t.day_count = 16'(pick_count());
         end else if (p < 85) begin
            t.cmd       = CMD_BACK;
            t.day_count = 16'(pick_count());
         end else begin
            t.cmd = CMD_READ;
         end
         send_cmd(t);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      sb      = new();
      no_idle = 1'b0;
      reset   = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_READ;
      req_chan.load_year  = 16'sd0;
      req_chan.load_month = 4'd1;
      req_chan.load_day   = 5'd1;
      req_chan.load_known = 3'd0;
      req_chan.day_count  = 16'd0;
      rsp_chan.ready      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      wait_drained();
      run_random();
      wait_drained();
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/cds_pkg.sv
src/cds_if.sv
src/cds_ctrl.sv
src/cds_dp.sv
src/calendar_date_stepper_top.sv
tb/sv/calendar_date_stepper_top_tb.sv
